@@ rtl/tql_pkg.sv @@
//------------------------------------------------------------------------------
// tql_pkg
// shared constants, types and fixed-point helpers of the q-learning engine
//------------------------------------------------------------------------------
package tql_pkg;

   localparam int STATE_COUNT = 1024;
   localparam int MAX_ACTIONS = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int STATE_BITS = $clog2(STATE_COUNT);
   localparam int ACTION_BITS = $clog2(MAX_ACTIONS);
   localparam int ADDR_BITS = STATE_BITS + ACTION_BITS;
   localparam int DEPTH = STATE_COUNT * MAX_ACTIONS;
   localparam int RATE_BITS = 17;
   localparam int COUNT_BITS = 5;
   localparam int WIDE_BITS = VALUE_WIDTH + 4;
   localparam logic [RATE_BITS-1:0] ONE_Q16 = 17'd65536;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_CHOOSE = 2'd1;
   localparam logic [1:0] OP_DECAY = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [2:0] REG_DISCOUNT = 3'd0;
   localparam logic [2:0] REG_LR_INIT = 3'd1;
   localparam logic [2:0] REG_EPS_INIT = 3'd2;
   localparam logic [2:0] REG_EPS_FINAL = 3'd3;
   localparam logic [2:0] REG_DECAY = 3'd4;
   localparam logic [2:0] REG_ACTION_COUNT = 3'd5;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CLEAR = 9'b000000010,
      ST_SCAN  = 9'b000000100,
      ST_DRAIN = 9'b000001000,
      ST_OLD   = 9'b000010000,
      ST_MUL1  = 9'b000100000,
      ST_MUL2  = 9'b001000000,
      ST_WRITE = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan_start;
      logic scan_rd;
      logic old_rd;
      logic mul1;
      logic mul2;
      logic wr;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_last;
      logic [1:0] op;
   } status_type;

   function automatic logic [RATE_BITS-1:0] rate_of(input logic [RATE_BITS-1:0] r);
      rate_of = (r > ONE_Q16) ? ONE_Q16 : r;
   endfunction

endpackage

@@ rtl/tql_ram.sv @@
//------------------------------------------------------------------------------
// tql_ram
// generic single-port ram with registered read
//------------------------------------------------------------------------------
module tql_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ rtl/tql_ctrl.sv @@
//------------------------------------------------------------------------------
// tql_ctrl
// sequencer for clear, row scan, blend and result stages
//------------------------------------------------------------------------------
module tql_ctrl import tql_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic       rsp_free,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.op == OP_DECAY || status.op == OP_NOP) begin
               cmd.mul1 = 1'b1;
               state_in = ST_MUL2;
            end else begin
               cmd.scan_rd = 1'b1;
               if (status.scan_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.scan_start = 1'b1;
            state_in = (status.op == OP_UPDATE) ? ST_OLD : ST_OUT;
         end
         ST_OLD: begin
            cmd.old_rd = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = (status.op == OP_UPDATE) ? ST_WRITE : ST_OUT;
         end
         ST_WRITE: begin
            cmd.wr = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE) else $error("load outside idle");
   a_wr_update: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> status.op == OP_UPDATE) else $error("write on non-update");
   a_clear_first: assert property (@(posedge clock)
      $past(reset) && !reset |-> state_ff == ST_CLEAR) else $error("no clear pass");
endmodule

@@ rtl/tql_dp.sv @@
//------------------------------------------------------------------------------
// tql_dp
// datapath: q table, config registers, row max scan, fixed-point blend
//------------------------------------------------------------------------------
module tql_dp import tql_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [RATE_BITS-1:0]   csr_wdata,
   input  logic [1:0]             in_op,
   input  logic [STATE_BITS-1:0]  in_state,
   input  logic [ACTION_BITS-1:0] in_action,
   input  logic signed [VALUE_WIDTH-1:0] in_reward,
   input  logic [STATE_BITS-1:0]  in_next,
   input  logic [15:0]            in_frac,
   input  logic [ACTION_BITS-1:0] in_raction,
   output logic [ACTION_BITS-1:0] out_action,
   output logic signed [VALUE_WIDTH-1:0] out_value,
   output logic                   out_explored,
   output logic                   out_saturated,
   output logic [RATE_BITS-1:0]   out_eps,
   output logic [RATE_BITS-1:0]   out_lr
);
   localparam logic signed [WIDE_BITS-1:0] VMAX =
      WIDE_BITS'((64'sd1 <<< (VALUE_WIDTH-1)) - 1);
   localparam logic signed [WIDE_BITS-1:0] VMIN = -VMAX - 1;

   logic [RATE_BITS-1:0] discount_ff, eps_final_ff, decay_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [RATE_BITS-1:0] eps_ff, lr_ff, eps_in, lr_in;
   logic [1:0] op_ff;
   logic [STATE_BITS-1:0] state_ff, next_ff;
   logic [ACTION_BITS-1:0] action_ff, raction_ff, best_ff, best_in, rd_idx_ff, cmp_idx_ff;
   logic signed [VALUE_WIDTH-1:0] reward_ff, max_ff, max_in;
   logic [15:0] frac_ff;
   logic [ADDR_BITS-1:0] clr_ff;
   logic cmp_valid_ff, first_ff;
   logic [ADDR_BITS-1:0] addr;
   logic signed [VALUE_WIDTH-1:0] rd_data, old_ff;
   logic signed [WIDE_BITS-1:0] t_ff, res_ff, nv_in;
   logic signed [WIDE_BITS+RATE_BITS:0] prod_ff, prod2_ff;
   logic [ACTION_BITS:0] used;
   logic [ACTION_BITS-1:0] last_a, a_upd, a_rnd;
   logic [RATE_BITS-1:0] f_rate, fin;
   logic sat_in;

   always_comb begin
      if (count_ff == '0) used = (ACTION_BITS+1)'(1);
      else if (count_ff > COUNT_BITS'(MAX_ACTIONS)) used = (ACTION_BITS+1)'(MAX_ACTIONS);
      else used = (ACTION_BITS+1)'(count_ff);
      last_a = ACTION_BITS'(used - 1'b1);
      a_upd = ({1'b0, action_ff} >= used) ? last_a : action_ff;
      a_rnd = ({1'b0, raction_ff} >= used) ? last_a : raction_ff;
      f_rate = ONE_Q16 - rate_of(decay_ff);
      fin = rate_of(eps_final_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff <= 17'd62259;
         eps_final_ff <= 17'd3277; decay_ff <= 17'd655; count_ff <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            REG_DISCOUNT: discount_ff <= csr_wdata;
            REG_EPS_FINAL: eps_final_ff <= csr_wdata;
            REG_DECAY: decay_ff <= csr_wdata;
            REG_ACTION_COUNT: count_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ram address
   always_comb begin
      if (cmd.clear) addr = clr_ff;
      else if (cmd.scan_rd)
         addr = {(op_ff == OP_UPDATE) ? next_ff : state_ff, rd_idx_ff};
      else addr = {state_ff, a_upd};
   end

   tql_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(cmd.clear | cmd.wr), .addr(addr),
      .wr_data(cmd.clear ? '0 : res_ff[VALUE_WIDTH-1:0]), .rd_data(rd_data));

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + 1'b1;
   end

   assign status.clear_done = (clr_ff == ADDR_BITS'(DEPTH-1));
   assign status.scan_last = ({1'b0, rd_idx_ff} == used - 1'b1);
   assign status.op = op_ff;

   // row max compare, on each entry in the cycle after its read
   always_comb begin
      max_in = max_ff;
      best_in = best_ff;
      if (cmp_valid_ff && (first_ff || rd_data > max_ff)) begin
         max_in = rd_data;
         best_in = cmp_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op; state_ff <= in_state; next_ff <= in_next;
         action_ff <= in_action; reward_ff <= in_reward; frac_ff <= in_frac;
         raction_ff <= in_raction; rd_idx_ff <= '0;
         first_ff <= 1'b1;
      end else if (cmd.scan_rd) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
      cmp_valid_ff <= cmd.scan_rd;
      cmp_idx_ff <= rd_idx_ff;
      if (cmp_valid_ff) begin
         max_ff <= max_in; best_ff <= best_in; first_ff <= 1'b0;
      end
      if (cmd.mul1) old_ff <= rd_data;
   end

   // mulq: floor((v*r + 32768) / 65536) via arithmetic shift
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         prod_ff <= (WIDE_BITS+RATE_BITS+1)'(max_in)
                  * $signed({1'b0, rate_of(discount_ff)});
      end
      if (cmd.old_rd) begin
         t_ff <= WIDE_BITS'(reward_ff)
               + WIDE_BITS'((prod_ff + 32768) >>> 16);
      end
      if (cmd.mul1) begin
         prod2_ff <= (WIDE_BITS+RATE_BITS+1)'(t_ff - WIDE_BITS'(rd_data))
                   * $signed({1'b0, lr_ff});
      end
   end

   always_comb begin
      nv_in = WIDE_BITS'(old_ff) + WIDE_BITS'((prod2_ff + 32768) >>> 16);
      sat_in = 1'b0;
      if (nv_in > VMAX) begin nv_in = VMAX; sat_in = 1'b1; end
      if (nv_in < VMIN) begin nv_in = VMIN; sat_in = 1'b1; end
   end

   logic sat_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul2 && op_ff == OP_UPDATE) begin
         res_ff <= nv_in; sat_ff <= sat_in;
      end
   end

   // decay of rates
   logic [RATE_BITS+RATE_BITS:0] lr_prod;
   logic signed [RATE_BITS+RATE_BITS+1:0] eps_prod;
   logic [RATE_BITS+RATE_BITS:0] lr_pr_ff;
   logic signed [RATE_BITS+RATE_BITS+1:0] eps_pr_ff;
   assign lr_prod = (RATE_BITS+RATE_BITS+1)'(lr_ff) * f_rate;
   assign eps_prod = $signed({1'b0, eps_ff}) - $signed({1'b0, fin});

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         lr_pr_ff <= lr_prod;
         eps_pr_ff <= eps_prod * $signed({1'b0, f_rate});
      end
   end

   always_comb begin
      lr_in = lr_ff;
      eps_in = eps_ff;
      if (cmd.mul2 && op_ff == OP_DECAY) begin
         lr_in = RATE_BITS'((lr_pr_ff + 32768) >> 16);
         eps_in = RATE_BITS'($signed({1'b0, fin}) + ((eps_pr_ff + 32768) >>> 16));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= rate_of(17'd6554); eps_ff <= ONE_Q16;
      end else if (csr_we && csr_index == REG_LR_INIT) begin
         lr_ff <= rate_of(csr_wdata);
      end else if (csr_we && csr_index == REG_EPS_INIT) begin
         eps_ff <= rate_of(csr_wdata);
      end else begin
         lr_ff <= lr_in; eps_ff <= eps_in;
      end
   end

   // results
   logic explore;
   assign explore = ({1'b0, frac_ff} < eps_ff);
   always_comb begin
      out_action = '0; out_value = '0; out_explored = 1'b0; out_saturated = 1'b0;
      case (op_ff)
         OP_UPDATE: begin
            out_action = a_upd; out_value = res_ff[VALUE_WIDTH-1:0];
            out_saturated = sat_ff;
         end
         OP_CHOOSE: begin
            out_value = max_ff; out_explored = explore;
            out_action = explore ? a_rnd : best_ff;
         end
         default: ;
      endcase
   end
   assign out_eps = eps_ff;
   assign out_lr = lr_ff;

   a_lr_range: assert property (@(posedge clock) disable iff (reset)
      lr_ff <= ONE_Q16) else $error("learning rate above one");
   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> {1'b0, rd_idx_ff} < used) else $error("scan past row");
   a_rates_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |=> $stable(lr_ff)) else $error("rate moved during scan");
endmodule

@@ rtl/tabular_q_learning_engine.sv @@
//------------------------------------------------------------------------------
// tabular_q_learning_engine
// q table with update, epsilon-greedy choose and rate decay
//
// channel  dir  fields
// req      in   tdata: state, action, reward, next_row, frac, raction; tuser: opcode
// rsp      out  tdata: result_action, result_value, eps, lr; tuser: explored, saturated
// csr      in   we, index, wdata
//
// an update scans the next row, a choose the current row; decay and no-op skip the scan;
// the row scan reads one entry a cycle from the single ram port, over the active actions
// after reset a clearing pass zeroes all 16384 entries of the table, no request taken
// the result register holds while rsp_tready is low
//------------------------------------------------------------------------------
module tabular_q_learning_engine import tql_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // state[9:0] action[13:10] reward[45:14] next_row[55:46] frac[71:56] raction[75:72]
   input  logic [79:0]  req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_action[3:0] result_value[35:4] epsilon_now[52:36] learning_rate_now[69:53]
   output logic [71:0]  rsp_tdata,
   // explored[0] saturated[1]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [16:0]  csr_wdata
);
   cmd_type cmd;
   status_type status;
   logic busy, req_fire, rsp_valid_ff;
   logic [ACTION_BITS-1:0] o_action;
   logic signed [VALUE_WIDTH-1:0] o_value;
   logic o_expl, o_sat;
   logic [RATE_BITS-1:0] o_eps, o_lr;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;

   tql_ctrl u_ctrl (.clock(clock), .reset(reset), .req_fire(req_fire),
      .rsp_free(!rsp_valid_ff || rsp_tready), .status(status), .cmd(cmd), .busy(busy));

   tql_dp u_dp (.clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_op(req_tuser), .in_state(req_tdata[9:0]), .in_action(req_tdata[13:10]),
      .in_reward(req_tdata[45:14]), .in_next(req_tdata[55:46]),
      .in_frac(req_tdata[71:56]), .in_raction(req_tdata[75:72]),
      .out_action(o_action), .out_value(o_value), .out_explored(o_expl),
      .out_saturated(o_sat), .out_eps(o_eps), .out_lr(o_lr));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_tdata <= {2'b00, o_lr, o_eps, o_value, o_action};
         rsp_tuser <= {o_sat, o_expl};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_fire) else $error("request taken while busy");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_tvalid || rsp_tready) else $error("response overwritten");
endmodule
